/* src/crs_pkg.sv */
// Shared types and constants for the CVT ratio scheduler.
// Holds the command struct between controller and datapath, the register
// indexes, the drive mode and terrain codes, and the Q4.12 constants.
package crs_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int CNT_W = 8;
	localparam int VIOLATION_LIMIT_DEF = 5;

	// Numerator of the pedal term, quotient and working ratio widths.
	localparam int NUM_W = 24;
	localparam int QUO_W = 13;
	localparam int RAT_W = 17;
	localparam int MUL_B_W = 16;
	localparam int PROD_W = NUM_W + MUL_B_W;
	// Reciprocals are floor(2^RECIP_SH / divisor).
	localparam int RECIP_SH = 24;
	localparam int QFRAC = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DRIVE_MODE = 3'd0,
		CFG_MIN_RATIO = 3'd1,
		CFG_MAX_RATIO = 3'd2,
		CFG_OIL_TEMP_LIMIT = 3'd3,
		CFG_ENGINE_SPEED_FLOOR = 3'd4
	} crs_cfg_e;

	typedef enum logic [1:0] {
		MODE_MANUAL = 2'd0,
		MODE_PLOWING = 2'd1,
		MODE_SEEDING = 2'd2,
		MODE_TRANSPORT = 2'd3
	} crs_mode_e;

	typedef enum logic [1:0] {
		TERRAIN_FLAT = 2'd0,
		TERRAIN_HILLY = 2'd1,
		TERRAIN_STEEP = 2'd2,
		TERRAIN_OTHER = 2'd3
	} crs_terrain_e;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_PNUM = 3'd1,
		OP_PREC = 3'd2,
		OP_PCOR = 3'd3,
		OP_BASE = 3'd4,
		OP_SC1 = 3'd5,
		OP_SC2 = 3'd6,
		OP_SC3 = 3'd7
	} crs_op_e;

	typedef struct packed {
		logic capture;
		crs_op_e op;
		logic out_write;
		logic issued;
	} crs_cmd_t;

	// Q4.12 constants.
	localparam logic [15:0] Q_0P9 = 16'd3686;
	localparam logic [15:0] Q_1P1 = 16'd4506;
	localparam logic [15:0] Q_0P8 = 16'd3277;
	localparam logic [15:0] Q_0P7 = 16'd2867;
	localparam logic [15:0] Q_0P6 = 16'd2458;
	localparam logic [15:0] Q_1P2 = 16'd4915;
	localparam logic [15:0] Q_1P5 = 16'd6144;
	localparam logic [15:0] Q_1P6 = 16'd6554;
	localparam logic [15:0] Q_1P8 = 16'd7373;
	localparam logic [15:0] Q_0P5 = 16'd2048;
	localparam logic [15:0] Q_TENTH = 16'd410;

	// Pedal term numerators, divisors and their reciprocals.
	localparam logic [15:0] PED_NUM_MANUAL = 16'd6144;
	localparam logic [15:0] PED_NUM_SEEDING = 16'd2048;
	localparam logic [15:0] PED_NUM_TRANSPORT = 16'd12288;
	localparam logic [15:0] DIV_SMALL = 16'd1000;
	localparam logic [15:0] DIV_LARGE = 16'd10000;
	localparam logic [15:0] RECIP_SMALL = 16'((64'd1 << RECIP_SH) / 64'd1000);
	localparam logic [15:0] RECIP_LARGE = 16'((64'd1 << RECIP_SH) / 64'd10000);

	// Reset values of the configuration registers.
	localparam logic [15:0] MIN_RATIO_RST = 16'd2048;
	localparam logic [15:0] MAX_RATIO_RST = 16'd10240;
	localparam logic signed [11:0] OIL_LIMIT_RST = 12'sd1100;
	localparam logic [12:0] RPM_FLOOR_RST = 13'd800;

	// Thresholds.
	localparam logic [9:0] LOAD_HEAVY = 10'd800;
	localparam logic [9:0] LOAD_MEDIUM = 10'd600;
	localparam logic [9:0] LOAD_SEED = 10'd700;
	localparam logic [9:0] PLOAD_HIGH = 10'd800;
	localparam logic [9:0] PLOAD_LOW = 10'd300;
	localparam logic [12:0] SPEED_PLOW_SLOW = 13'd200;
	localparam logic [12:0] SPEED_HOLD_LO = 13'd50;
	localparam logic [12:0] SPEED_HOLD_HI = 13'd300;
	localparam logic [12:0] SPEED_FAST = 13'd1000;
	localparam logic [12:0] SPEED_MID = 13'd500;

endpackage

/* src/crs_ctrl.sv */
// Controller of the CVT ratio scheduler: sequencer, safety counter and
// result flags. Drives the datapath through crs_cmd_t; depends on crs_pkg.
module crs_ctrl #(
	parameter int VIOLATION_LIMIT = crs_pkg::VIOLATION_LIMIT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	output logic target_issued,
	output logic safety_fault,
	output logic shut_off,
	input logic sample_fault,
	output crs_pkg::crs_cmd_t cmd
);
	import crs_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_PREC,
		ST_PCOR,
		ST_BASE,
		ST_SC1,
		ST_SC2,
		ST_SC3,
		ST_DONE
	} state_t;

	localparam logic [CNT_W-1:0] LIMIT = CNT_W'(VIOLATION_LIMIT);

	state_t state_q;
	logic [CNT_W-1:0] viol_cnt_q;
	logic enabled_q;
	logic iss_q;
	logic flt_q;
	logic shut_q;
	logic out_valid_q;
	logic issued_q;
	logic fault_out_q;
	logic shut_out_q;
	logic out_free;
	logic [CNT_W-1:0] cnt_inc;

	assign out_free = !out_valid_q || !out_stall;
	assign cnt_inc = (viol_cnt_q == {CNT_W{1'b1}}) ? viol_cnt_q : viol_cnt_q + CNT_W'(1);
	assign in_stall = (state_q != ST_IDLE);

	assign out_valid = out_valid_q;
	assign target_issued = issued_q;
	assign safety_fault = fault_out_q;
	assign shut_off = shut_out_q;

	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && in_valid;
		cmd.out_write = (state_q == ST_DONE) && out_free;
		cmd.issued = iss_q;
		case (state_q)
			ST_CHECK: cmd.op = OP_PNUM;
			ST_PREC: cmd.op = OP_PREC;
			ST_PCOR: cmd.op = OP_PCOR;
			ST_BASE: cmd.op = OP_BASE;
			ST_SC1: cmd.op = OP_SC1;
			ST_SC2: cmd.op = OP_SC2;
			ST_SC3: cmd.op = OP_SC3;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			viol_cnt_q <= '0;
			enabled_q <= 1'b1;
			iss_q <= 1'b0;
			flt_q <= 1'b0;
			shut_q <= 1'b0;
			out_valid_q <= 1'b0;
			issued_q <= 1'b0;
			fault_out_q <= 1'b0;
			shut_out_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !cmd.out_write) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					// The datapath starts the pedal product here whatever the
					// outcome; an early exit simply ignores it.
					if (!enabled_q) begin
						iss_q <= 1'b0;
						flt_q <= 1'b0;
						shut_q <= 1'b1;
						state_q <= ST_DONE;
					end else if (sample_fault) begin
						viol_cnt_q <= cnt_inc;
						flt_q <= 1'b1;
						if (cnt_inc >= LIMIT) begin
							enabled_q <= 1'b0;
							iss_q <= 1'b0;
							shut_q <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							iss_q <= 1'b1;
							shut_q <= 1'b0;
							state_q <= ST_PREC;
						end
					end else begin
						viol_cnt_q <= '0;
						iss_q <= 1'b1;
						flt_q <= 1'b0;
						shut_q <= 1'b0;
						state_q <= ST_PREC;
					end
				end
				ST_PREC: state_q <= ST_PCOR;
				ST_PCOR: state_q <= ST_BASE;
				ST_BASE: state_q <= ST_SC1;
				ST_SC1: state_q <= ST_SC2;
				ST_SC2: state_q <= ST_SC3;
				ST_SC3: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						issued_q <= iss_q;
						fault_out_q <= flt_q;
						shut_out_q <= shut_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* src/crs_datapath.sv */
// Datapath of the CVT ratio scheduler: configuration registers, sample
// capture, safety compare, shared constant multiplier and the clamp.
// Depends on crs_pkg; sequenced by crs_ctrl.
module crs_datapath (
	input logic clk,
	input logic arst_n,
	input logic cfg_wen,
	input logic [crs_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [crs_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic [9:0] pedal_position,
	input logic [9:0] engine_load,
	input logic [12:0] ground_speed,
	input logic [1:0] terrain,
	input logic signed [11:0] oil_temperature,
	input logic [12:0] engine_speed,
	input logic sample_valid,
	input logic [9:0] predicted_load,
	input logic [15:0] present_ratio,
	input crs_pkg::crs_cmd_t cmd,
	output logic sample_fault,
	output logic [15:0] target_ratio
);
	import crs_pkg::*;

	crs_mode_e mode_q;
	logic [15:0] min_q;
	logic [15:0] max_q;
	logic signed [11:0] oil_lim_q;
	logic [12:0] rpm_floor_q;

	logic [9:0] pedal_q;
	logic [9:0] load_q;
	logic [12:0] speed_q;
	crs_terrain_e terrain_q;
	logic signed [11:0] temp_q;
	logic [12:0] rpm_q;
	logic valid_q;
	logic [9:0] pload_q;
	logic [15:0] present_q;

	logic [NUM_W-1:0] acc_q;
	logic [QUO_W-1:0] quo_q;
	logic [RAT_W-1:0] r_q;
	logic [15:0] target_ratio_q;

	logic [MUL_B_W-1:0] ped_num;
	logic [MUL_B_W-1:0] div_recip;
	logic [MUL_B_W-1:0] div_const;
	logic [RAT_W-1:0] base_val;
	logic scale_en;
	logic [MUL_B_W-1:0] scale_c;
	logic hold_en;
	logic [RAT_W-1:0] present_x;
	logic [RAT_W-1:0] hold_diff;
	logic [NUM_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0] prod;
	logic [NUM_W-1:0] rem;
	logic corr;
	logic [15:0] sat_val;
	logic [15:0] hi_val;
	logic [15:0] clamp_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_MANUAL;
			min_q <= MIN_RATIO_RST;
			max_q <= MAX_RATIO_RST;
			oil_lim_q <= OIL_LIMIT_RST;
			rpm_floor_q <= RPM_FLOOR_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_DRIVE_MODE: mode_q <= crs_mode_e'(cfg_data[1:0]);
				CFG_MIN_RATIO: min_q <= cfg_data[15:0];
				CFG_MAX_RATIO: max_q <= cfg_data[15:0];
				CFG_OIL_TEMP_LIMIT: oil_lim_q <= cfg_data[11:0];
				CFG_ENGINE_SPEED_FLOOR: rpm_floor_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	assign sample_fault = (temp_q > oil_lim_q)
		|| ((rpm_q != '0) && (rpm_q < rpm_floor_q))
		|| !valid_q;

	always_comb begin
		case (mode_q)
			MODE_SEEDING: begin
				ped_num = PED_NUM_SEEDING;
				div_recip = RECIP_SMALL;
				div_const = DIV_SMALL;
			end
			MODE_TRANSPORT: begin
				ped_num = PED_NUM_TRANSPORT;
				div_recip = RECIP_LARGE;
				div_const = DIV_LARGE;
			end
			default: begin
				ped_num = PED_NUM_MANUAL;
				div_recip = RECIP_SMALL;
				div_const = DIV_SMALL;
			end
		endcase
	end

	always_comb begin
		case (mode_q)
			MODE_PLOWING: begin
				if (load_q > LOAD_HEAVY) begin
					base_val = RAT_W'(Q_0P6);
				end else if (load_q > LOAD_MEDIUM) begin
					base_val = RAT_W'(Q_0P7);
				end else begin
					base_val = RAT_W'(Q_0P8);
				end
			end
			MODE_SEEDING: base_val = RAT_W'(Q_1P2) + RAT_W'(quo_q);
			MODE_TRANSPORT: begin
				if (speed_q > SPEED_FAST) begin
					base_val = RAT_W'(Q_1P8) + RAT_W'(quo_q);
				end else if (speed_q > SPEED_MID) begin
					base_val = RAT_W'(Q_1P6) + RAT_W'(quo_q);
				end else begin
					base_val = RAT_W'(Q_1P5) + RAT_W'(quo_q);
				end
			end
			default: base_val = RAT_W'(Q_0P5) + RAT_W'(quo_q);
		endcase
	end

	// Which factor, if any, each scaling step applies.
	always_comb begin
		scale_en = 1'b0;
		scale_c = Q_0P9;
		case (cmd.op)
			OP_SC1: begin
				case (mode_q)
					MODE_PLOWING: scale_en = (speed_q < SPEED_PLOW_SLOW);
					MODE_SEEDING: scale_en = (load_q > LOAD_SEED);
					MODE_TRANSPORT: begin
						if (terrain_q == TERRAIN_FLAT) begin
							scale_en = 1'b1;
							scale_c = Q_1P1;
						end else if (terrain_q == TERRAIN_STEEP) begin
							scale_en = 1'b1;
						end
					end
					default: ;
				endcase
			end
			OP_SC2: begin
				if (mode_q == MODE_PLOWING) begin
					if (terrain_q == TERRAIN_STEEP) begin
						scale_en = 1'b1;
						scale_c = Q_0P8;
					end else if (terrain_q == TERRAIN_HILLY) begin
						scale_en = 1'b1;
					end
				end
			end
			OP_SC3: begin
				if (pload_q > PLOAD_HIGH) begin
					scale_en = 1'b1;
				end else if (pload_q < PLOAD_LOW) begin
					scale_en = 1'b1;
					scale_c = Q_1P1;
				end
			end
			default: ;
		endcase
	end

	// Seeding holds the present ratio when it is within a tenth of the target.
	assign present_x = RAT_W'(present_q);
	assign hold_diff = (r_q > present_x) ? (r_q - present_x) : (present_x - r_q);
	assign hold_en = (cmd.op == OP_SC2) && (mode_q == MODE_SEEDING)
		&& (speed_q > SPEED_HOLD_LO) && (speed_q < SPEED_HOLD_HI)
		&& (hold_diff < RAT_W'(Q_TENTH));

	always_comb begin
		case (cmd.op)
			OP_PNUM: begin
				mul_a = NUM_W'(pedal_q);
				mul_b = ped_num;
			end
			OP_PREC: begin
				mul_a = acc_q;
				mul_b = div_recip;
			end
			OP_PCOR: begin
				mul_a = NUM_W'(quo_q);
				mul_b = div_const;
			end
			default: begin
				mul_a = NUM_W'(r_q);
				mul_b = scale_c;
			end
		endcase
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	// The reciprocal estimate is low by at most one; one compare fixes it.
	assign rem = acc_q - prod[NUM_W-1:0];
	assign corr = (rem >= NUM_W'(div_const));

	assign sat_val = r_q[RAT_W-1] ? 16'hFFFF : r_q[15:0];
	assign hi_val = (sat_val > max_q) ? max_q : sat_val;
	assign clamp_val = (hi_val < min_q) ? min_q : hi_val;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pedal_q <= pedal_position;
			load_q <= engine_load;
			speed_q <= ground_speed;
			terrain_q <= crs_terrain_e'(terrain);
			temp_q <= oil_temperature;
			rpm_q <= engine_speed;
			valid_q <= sample_valid;
			pload_q <= predicted_load;
			present_q <= present_ratio;
		end
		case (cmd.op)
			OP_PNUM: acc_q <= prod[NUM_W-1:0];
			OP_PREC: quo_q <= prod[RECIP_SH +: QUO_W];
			OP_PCOR: quo_q <= quo_q + QUO_W'(corr);
			OP_BASE: r_q <= base_val;
			OP_SC2: begin
				if (hold_en) begin
					r_q <= present_x;
				end else if (scale_en) begin
					r_q <= prod[QFRAC +: RAT_W];
				end
			end
			OP_SC1, OP_SC3: begin
				if (scale_en) begin
					r_q <= prod[QFRAC +: RAT_W];
				end
			end
			default: ;
		endcase
		if (cmd.out_write) begin
			target_ratio_q <= cmd.issued ? clamp_val : 16'd0;
		end
	end

	assign target_ratio = target_ratio_q;

endmodule

/* src/cvt_ratio_scheduler_core.sv */
// Top level of the CVT ratio scheduler: joins controller and datapath.
// Depends on crs_pkg, crs_ctrl and crs_datapath.
//
//   channel   handshake            beat contents
//   cfg       cfg_wen              cfg_index, cfg_data (register write)
//   in        in_valid / in_stall  one sensor sample
//   out       out_valid / out_stall target_issued, target_ratio,
//                                  safety_fault, shut_off
//
// A sample passes the check with the pedal product, then the reciprocal,
// correction, base and three scaling steps on the one shared constant
// multiplier, and the clamp, to its result beat. A sample that finds the
// block latched off, or that latches it off, goes from the check straight
// to its result beat. in_stall is high while a sample is in work. A finished
// result waits in the output register, and the next sample can be worked on
// meanwhile; it holds in its last step until the output register frees up.
// Reset restores the register defaults, clears the violation count and
// enables the block; a latched shut-off clears only by reset.
module cvt_ratio_scheduler_core #(
	parameter int VIOLATION_LIMIT = crs_pkg::VIOLATION_LIMIT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wen,
	input logic [crs_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [crs_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [9:0] pedal_position,
	input logic [9:0] engine_load,
	input logic [12:0] ground_speed,
	input logic [1:0] terrain,
	input logic signed [11:0] oil_temperature,
	input logic [12:0] engine_speed,
	input logic sample_valid,
	input logic [9:0] predicted_load,
	input logic [15:0] present_ratio,
	output logic out_valid,
	input logic out_stall,
	output logic target_issued,
	output logic [15:0] target_ratio,
	output logic safety_fault,
	output logic shut_off
);
	import crs_pkg::*;

	crs_cmd_t cmd;
	logic sample_fault;

	crs_ctrl #(
		.VIOLATION_LIMIT(VIOLATION_LIMIT)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.target_issued(target_issued),
		.safety_fault(safety_fault),
		.shut_off(shut_off),
		.sample_fault(sample_fault),
		.cmd(cmd)
	);

	crs_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pedal_position(pedal_position),
		.engine_load(engine_load),
		.ground_speed(ground_speed),
		.terrain(terrain),
		.oil_temperature(oil_temperature),
		.engine_speed(engine_speed),
		.sample_valid(sample_valid),
		.predicted_load(predicted_load),
		.present_ratio(present_ratio),
		.cmd(cmd),
		.sample_fault(sample_fault),
		.target_ratio(target_ratio)
	);

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for cvt_ratio_scheduler_core: predicts every result beat
// from its own copy of the registers and violation state, and checks each field.
// Depends on crs_pkg and the RTL of the ratio scheduler.
module testbench;
	import crs_pkg::*;

	localparam int VIOLATION_LIMIT = VIOLATION_LIMIT_DEF;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASE_SAMPLES = 190;

	typedef struct {
		logic [9:0] pedal;
		logic [9:0] load;
		logic [12:0] speed;
		crs_terrain_e terrain;
		logic signed [11:0] oil_temp;
		logic [12:0] rpm;
		logic data_ok;
		logic [9:0] pload;
		logic [15:0] present;
	} sensor_sample_t;

	typedef struct {
		logic issued;
		logic [15:0] ratio;
		logic fault;
		logic shut;
	} ratio_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [9:0] pedal_position = '0;
	logic [9:0] engine_load = '0;
	logic [12:0] ground_speed = '0;
	logic [1:0] terrain = '0;
	logic signed [11:0] oil_temperature = '0;
	logic [12:0] engine_speed = '0;
	logic sample_valid = 1'b0;
	logic [9:0] predicted_load = '0;
	logic [15:0] present_ratio = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic target_issued;
	logic [15:0] target_ratio;
	logic safety_fault;
	logic shut_off;

	// Register copy and violation state of the scheduler.
	crs_mode_e mode_cfg = MODE_MANUAL;
	logic [15:0] min_cfg = MIN_RATIO_RST;
	logic [15:0] max_cfg = MAX_RATIO_RST;
	logic signed [11:0] oil_limit_cfg = OIL_LIMIT_RST;
	logic [12:0] rpm_floor_cfg = RPM_FLOOR_RST;
	int unsigned violations = 0;
	logic ratio_enabled = 1'b1;

	sensor_sample_t samples_pending[$];
	ratio_beat_t beats_expected[$];
	sensor_sample_t sample_now;
	ratio_beat_t beat_want;
	int mismatch_count = 0;
	int fault_run = 0;
	int stall_level = 0;
	int gap_max = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_left = 0;
	int free_left = 0;

	cvt_ratio_scheduler_core #(.VIOLATION_LIMIT(VIOLATION_LIMIT)) dut (.*);

	always #5 clk = ~clk;

	function automatic int pick_int(int lo, int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	function automatic int unsigned q_scale(int unsigned x, logic [15:0] c);
		longint unsigned p;
		p = 64'(x) * 64'(c);
		return 32'(p >> QFRAC);
	endfunction

	function automatic int unsigned pedal_term(logic [9:0] pedal, logic [15:0] num,
			logic [15:0] div);
		int unsigned p;
		p = pedal;
		return (p * num) / div;
	endfunction

	function automatic int unsigned seed_base(logic [9:0] pedal, logic [9:0] load);
		int unsigned r;
		r = Q_1P2 + pedal_term(pedal, PED_NUM_SEEDING, DIV_SMALL);
		if (load > LOAD_SEED)
			r = q_scale(r, Q_0P9);
		return r;
	endfunction

	function automatic logic fails_safety(sensor_sample_t s);
		return (s.oil_temp > oil_limit_cfg) || (s.rpm != 0 && s.rpm < rpm_floor_cfg) || !s.data_ok;
	endfunction

	// Updates the violation state and returns the beat this sample produces.
	function automatic ratio_beat_t schedule_ratio(sensor_sample_t s);
		ratio_beat_t b;
		int unsigned r;
		int unsigned d;
		b = '{issued: 1'b0, ratio: 16'd0, fault: 1'b0, shut: 1'b0};
		if (!ratio_enabled) begin
			b.shut = 1'b1;
			return b;
		end
		if (fails_safety(s)) begin
			if (violations < 255)
				violations++;
			b.fault = 1'b1;
			if (violations >= VIOLATION_LIMIT) begin
				ratio_enabled = 1'b0;
				b.shut = 1'b1;
				return b;
			end
		end else
			violations = 0;
		case (mode_cfg)
			MODE_PLOWING: begin
				r = Q_0P8;
				if (s.load > LOAD_HEAVY)
					r = Q_0P6;
				else if (s.load > LOAD_MEDIUM)
					r = Q_0P7;
				if (s.speed < SPEED_PLOW_SLOW)
					r = q_scale(r, Q_0P9);
				if (s.terrain == TERRAIN_STEEP)
					r = q_scale(r, Q_0P8);
				else if (s.terrain == TERRAIN_HILLY)
					r = q_scale(r, Q_0P9);
			end
			MODE_SEEDING: begin
				r = seed_base(s.pedal, s.load);
				if (s.speed > SPEED_HOLD_LO && s.speed < SPEED_HOLD_HI) begin
					d = (s.present > r) ? s.present - r : r - s.present;
					if (d < Q_TENTH)
						r = s.present;
				end
			end
			MODE_TRANSPORT: begin
				r = Q_1P5;
				if (s.speed > SPEED_FAST)
					r = Q_1P8;
				else if (s.speed > SPEED_MID)
					r = Q_1P6;
				r += pedal_term(s.pedal, PED_NUM_TRANSPORT, DIV_LARGE);
				if (s.terrain == TERRAIN_FLAT)
					r = q_scale(r, Q_1P1);
				else if (s.terrain == TERRAIN_STEEP)
					r = q_scale(r, Q_0P9);
			end
			default: r = Q_0P5 + pedal_term(s.pedal, PED_NUM_MANUAL, DIV_SMALL);
		endcase
		if (s.pload > PLOAD_HIGH)
			r = q_scale(r, Q_0P9);
		else if (s.pload < PLOAD_LOW)
			r = q_scale(r, Q_1P1);
		if (r > 32'hFFFF)
			r = 32'hFFFF;
		if (r > max_cfg)
			r = max_cfg;
		if (r < min_cfg)
			r = min_cfg;
		b.issued = 1'b1;
		b.ratio = 16'(r);
		return b;
	endfunction

	// A sample that passes every safety check under the current registers, with
	// its content pushed toward the thresholds of the ratio schedule.
	function automatic sensor_sample_t clean_sample();
		sensor_sample_t s;
		case ($urandom_range(0, 9))
			0: s.pedal = 10'd0;
			1: s.pedal = 10'd1000;
			default: s.pedal = 10'($urandom_range(0, 1000));
		endcase
		if ($urandom_range(0, 2) == 0)
			s.load = 10'(600 + 100 * $urandom_range(0, 2) + $urandom_range(0, 1));
		else
			s.load = 10'($urandom_range(0, 1000));
		case ($urandom_range(0, 9))
			0: s.speed = 13'(50 + $urandom_range(0, 1));
			1: s.speed = 13'(199 + $urandom_range(0, 1));
			2: s.speed = 13'(299 + $urandom_range(0, 1));
			3: s.speed = 13'(500 + $urandom_range(0, 1));
			4: s.speed = 13'(1000 + $urandom_range(0, 1));
			5: s.speed = ($urandom_range(0, 1) == 0) ? 13'd0 : 13'd5000;
			6, 7: s.speed = 13'($urandom_range(51, 299));
			default: s.speed = 13'($urandom_range(0, 5000));
		endcase
		s.terrain = crs_terrain_e'($urandom_range(0, 3));
		if ($urandom_range(0, 9) == 0)
			s.oil_temp = oil_limit_cfg;
		else
			s.oil_temp = 12'(pick_int(-400, int'(oil_limit_cfg)));
		case ($urandom_range(0, 9))
			0, 1: s.rpm = 13'd0;
			2: s.rpm = rpm_floor_cfg;
			default: s.rpm = 13'(pick_int(int'(rpm_floor_cfg), 8000));
		endcase
		s.data_ok = 1'b1;
		case ($urandom_range(0, 9))
			0: s.pload = 10'd0;
			1: s.pload = 10'd1000;
			2: s.pload = 10'(299 + $urandom_range(0, 1));
			3: s.pload = 10'(800 + $urandom_range(0, 1));
			default: s.pload = 10'($urandom_range(0, 1000));
		endcase
		// Half the time the present ratio sits near the seeding base so that the
		// hold window is hit from both sides.
		if ($urandom_range(0, 1) == 0)
			s.present = 16'(int'(seed_base(s.pedal, s.load)) + pick_int(-420, 420));
		else
			s.present = 16'($urandom_range(0, 65535));
		return s;
	endfunction

	function automatic sensor_sample_t faulty_sample();
		sensor_sample_t s;
		s = clean_sample();
		case ($urandom_range(0, 2))
			0: begin
				if (oil_limit_cfg < 12'sd1500)
					s.oil_temp = 12'(pick_int(int'(oil_limit_cfg) + 1, 1500));
				else
					s.data_ok = 1'b0;
			end
			1: begin
				if (rpm_floor_cfg > 13'd1)
					s.rpm = 13'(pick_int(1, int'(rpm_floor_cfg) - 1));
				else
					s.data_ok = 1'b0;
			end
			default: s.data_ok = 1'b0;
		endcase
		return s;
	endfunction

	function automatic void queue_sample(sensor_sample_t s);
		samples_pending.push_back(s);
		fault_run = fails_safety(s) ? fault_run + 1 : 0;
	endfunction

	// Faults are mixed in, but never enough in a row to latch the block off.
	function automatic void queue_random(int count);
		for (int i = 0; i < count; i++)
			if (fault_run < VIOLATION_LIMIT - 1 && $urandom_range(0, 99) < 15)
				queue_sample(faulty_sample());
			else
				queue_sample(clean_sample());
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	task automatic write_reg(crs_cfg_e idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
	endtask

	task automatic load_config(crs_mode_e mode, logic [15:0] lo, logic [15:0] hi,
			logic signed [11:0] oil, logic [12:0] rpm_floor);
		mode_cfg = mode;
		min_cfg = lo;
		max_cfg = hi;
		oil_limit_cfg = oil;
		rpm_floor_cfg = rpm_floor;
		write_reg(CFG_DRIVE_MODE, 16'(mode));
		write_reg(CFG_MIN_RATIO, lo);
		write_reg(CFG_MAX_RATIO, hi);
		write_reg(CFG_OIL_TEMP_LIMIT, 16'(oil));
		write_reg(CFG_ENGINE_SPEED_FLOOR, 16'(rpm_floor));
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// Idle is judged at the falling edge, once all updates of the rising edge are in.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (samples_pending.size() != 0 || in_valid || beats_expected.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sample driver: bursts of beats separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall)
				beats_expected.push_back(schedule_ratio(sample_now));
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (samples_pending.size() > 0) begin
					sample_now = samples_pending.pop_front();
					pedal_position <= sample_now.pedal;
					engine_load <= sample_now.load;
					ground_speed <= sample_now.speed;
					terrain <= sample_now.terrain;
					oil_temperature <= sample_now.oil_temp;
					engine_speed <= sample_now.rpm;
					sample_valid <= sample_now.data_ok;
					predicted_load <= sample_now.pload;
					present_ratio <= sample_now.present;
					in_valid <= 1'b1;
					if (burst_left > 0)
						burst_left--;
					else begin
						burst_left = $urandom_range(0, 24);
						gap_left = (gap_max > 0) ? $urandom_range(1, gap_max) : 0;
					end
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Result monitor and output stall pattern.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			free_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (beats_expected.size() == 0) begin
					$display("%0t: result beat with nothing expected, actual ratio %0d",
						$time, target_ratio);
					mismatch_count++;
				end else begin
					beat_want = beats_expected.pop_front();
					check_field("target_issued", beat_want.issued, target_issued);
					check_field("target_ratio", beat_want.ratio, target_ratio);
					check_field("safety_fault", beat_want.fault, safety_fault);
					check_field("shut_off", beat_want.shut, shut_off);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (free_left > 0 || stall_level == 0) begin
				if (free_left > 0)
					free_left--;
				out_stall <= 1'b0;
			end else begin
				stall_left = (stall_level == 1) ? $urandom_range(0, 2) : $urandom_range(0, 5);
				free_left = (stall_level == 1) ? $urandom_range(1, 8) : $urandom_range(0, 2);
				out_stall <= 1'b1;
			end
		end
	end

	initial begin
		sensor_sample_t s;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (int phase = 0; phase < 10; phase++) begin
			stall_level = phase % 3;
			gap_max = (phase / 3 == 1) ? 0 : ((phase % 2 == 0) ? 12 : 4);
			case (phase)
				0: ;
				1: load_config(MODE_PLOWING, MIN_RATIO_RST, MAX_RATIO_RST, OIL_LIMIT_RST,
					RPM_FLOOR_RST);
				2: load_config(MODE_SEEDING, MIN_RATIO_RST, MAX_RATIO_RST, OIL_LIMIT_RST,
					RPM_FLOOR_RST);
				3: load_config(MODE_TRANSPORT, MIN_RATIO_RST, MAX_RATIO_RST, OIL_LIMIT_RST,
					RPM_FLOOR_RST);
				4: load_config(MODE_MANUAL, 16'd0, 16'hFFFF, -12'sd400, 13'd0);
				// Crossed bounds: the lower bound has to win.
				5: load_config(MODE_TRANSPORT, 16'hFFFF, 16'd0, 12'sd1500, 13'd8000);
				6: load_config(MODE_SEEDING, 16'd7000, 16'd5000, 12'sd0, 13'd1);
				default: load_config(crs_mode_e'($urandom_range(0, 3)),
					16'($urandom_range(0, 8000)), 16'($urandom_range(3000, 65535)),
					12'(pick_int(-400, 1500)), 13'($urandom_range(0, 8000)));
			endcase

			case (phase)
				0: begin
					s = clean_sample(); s.pedal = 10'd0; s.present = 16'd0;
					s.oil_temp = -12'sd400; s.speed = 13'd5000; s.pload = 10'd0;
					queue_sample(s);
					s = clean_sample(); s.pedal = 10'd1000; s.present = 16'hFFFF;
					s.rpm = 13'd8000; s.pload = 10'd1000; s.oil_temp = OIL_LIMIT_RST;
					queue_sample(s);
					s = clean_sample(); s.pload = PLOAD_LOW; queue_sample(s);
					s = clean_sample(); s.pload = PLOAD_HIGH; queue_sample(s);
					// Four faults in a row stay below the limit and still issue a target.
					s = clean_sample(); s.data_ok = 1'b0; queue_sample(s);
					s = clean_sample(); s.oil_temp = 12'sd1500; queue_sample(s);
					s = clean_sample(); s.rpm = RPM_FLOOR_RST - 13'd1; queue_sample(s);
					s = clean_sample(); s.rpm = 13'd1; queue_sample(s);
					s = clean_sample(); s.rpm = 13'd0; queue_sample(s);
				end
				1: begin
					s = clean_sample(); s.load = LOAD_HEAVY + 10'd1;
					s.speed = SPEED_PLOW_SLOW - 13'd1; s.terrain = TERRAIN_STEEP;
					queue_sample(s);
					s = clean_sample(); s.load = LOAD_MEDIUM + 10'd1;
					s.speed = SPEED_PLOW_SLOW; s.terrain = TERRAIN_HILLY;
					queue_sample(s);
					s = clean_sample(); s.load = LOAD_MEDIUM; s.terrain = TERRAIN_FLAT;
					queue_sample(s);
					s = clean_sample(); s.load = LOAD_HEAVY; s.terrain = TERRAIN_OTHER;
					queue_sample(s);
				end
				2: begin
					s = clean_sample(); s.speed = 13'd100;
					s.present = 16'(seed_base(s.pedal, s.load) + 409);
					queue_sample(s);
					s = clean_sample(); s.speed = 13'd100;
					s.present = 16'(seed_base(s.pedal, s.load) - 410);
					queue_sample(s);
					s = clean_sample(); s.speed = 13'd299; s.load = LOAD_SEED + 10'd1;
					s.present = 16'(seed_base(s.pedal, s.load) - 409);
					queue_sample(s);
					// The hold window is open at both ends.
					s = clean_sample(); s.speed = SPEED_HOLD_LO;
					s.present = 16'(seed_base(s.pedal, s.load) + 100);
					queue_sample(s);
					s = clean_sample(); s.speed = SPEED_HOLD_HI;
					s.present = 16'(seed_base(s.pedal, s.load) + 100);
					queue_sample(s);
				end
				3: begin
					s = clean_sample(); s.speed = SPEED_FAST + 13'd1; s.pedal = 10'd1000;
					s.terrain = TERRAIN_FLAT; queue_sample(s);
					s = clean_sample(); s.speed = SPEED_MID + 13'd1; s.terrain = TERRAIN_STEEP;
					queue_sample(s);
					s = clean_sample(); s.speed = SPEED_MID; s.terrain = TERRAIN_HILLY;
					queue_sample(s);
					s = clean_sample(); s.speed = SPEED_FAST; s.terrain = TERRAIN_OTHER;
					queue_sample(s);
				end
				default: ;
			endcase

			queue_random(PHASE_SAMPLES / 2);
			wait_idle();
			queue_random(PHASE_SAMPLES - PHASE_SAMPLES / 2);
			wait_idle();
		end

		// Enough faults in a row to latch the block off; everything after that
		// must come back as shut off.
		for (int i = 0; i < VIOLATION_LIMIT; i++)
			queue_sample(faulty_sample());
		for (int i = 0; i < 10; i++)
			queue_sample((i % 2 == 0) ? clean_sample() : faulty_sample());
		wait_idle();

		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

/* files.f */
src/crs_pkg.sv
src/crs_ctrl.sv
src/crs_datapath.sv
src/cvt_ratio_scheduler_core.sv
tb/sv/testbench.sv
